// ===== rtl/core/wheel_button_report_mapper_assert.svh =====
// Assertion macros used by the wheel button report mapper RTL.
`ifndef WHEEL_BUTTON_REPORT_MAPPER_ASSERT_SVH
`define WHEEL_BUTTON_REPORT_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WBRM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbrm same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WBRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbrm next-cycle check failed");

`endif

// ===== rtl/core/wbrm_pkg.sv =====
// ----------------------------------------------------------------------------
// wbrm_pkg
// Types and constants of the wheel button report mapper.
// ----------------------------------------------------------------------------
package wbrm_pkg;

    localparam logic [15:0] HOLD_TIME_RESET = 16'd3000;
    localparam logic [3:0]  HAT_NEUTRAL     = 4'd8;

    typedef struct packed {
        logic [7:0]  dpad_bits;
        logic [15:0] wheel_button_bits;
        logic [7:0]  aux_history_bits;
        logic        adapter_present;
        logic [23:0] adapter_button_bytes;
        logic [1:0]  aux_button_pair;
        logic [7:0]  extra_button_bits;
        logic        block_system_key;
        logic        block_hat;
        logic [31:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  hat_code;
        logic [12:0] report_buttons;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  wheel_protocol;
        logic [7:0]  adapter_layout;
        logic [7:0]  first_axis_role;
        logic [7:0]  second_axis_role;
        logic [15:0] hold_time_ms;
    } cfg_t;

    typedef struct packed {
        logic        pending;
        logic [31:0] deadline;
    } hold_t;

    // Hat lookup; index is {up, down, left, right} style reordering of dpad bits.
    function automatic logic [3:0] hat_lookup(input logic [3:0] idx);
        logic [3:0] code;
        case (idx)
            4'd0:    code = 4'd8;
            4'd1:    code = 4'd2;
            4'd2:    code = 4'd6;
            4'd3:    code = 4'd8;
            4'd4:    code = 4'd4;
            4'd5:    code = 4'd3;
            4'd6:    code = 4'd5;
            4'd7:    code = 4'd0;
            4'd8:    code = 4'd0;
            4'd9:    code = 4'd1;
            4'd10:   code = 4'd7;
            4'd11:   code = 4'd0;
            4'd12:   code = 4'd8;
            4'd13:   code = 4'd0;
            4'd14:   code = 4'd2;
            default: code = 4'd5;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/wbrm_map.sv =====
// ----------------------------------------------------------------------------
// wbrm_map
// Combinational mapping of one button snapshot to a report, plus the
// next value of the system button hold tracker.
// ----------------------------------------------------------------------------
module wbrm_map
(
    input  wbrm_pkg::in_item_t  item,
    input  wbrm_pkg::cfg_t      cfg,
    input  wbrm_pkg::hold_t     hold,
    output wbrm_pkg::out_item_t report,
    output wbrm_pkg::hold_t     hold_next
);
    import wbrm_pkg::*;

    localparam logic [7:0] MODE_01 = 8'h01;
    localparam logic [7:0] MODE_03 = 8'h03;
    localparam logic [7:0] MODE_04 = 8'h04;
    localparam logic [7:0] MODE_06 = 8'h06;
    localparam logic [7:0] MODE_09 = 8'h09;
    localparam logic [7:0] MODE_0A = 8'h0a;
    localparam logic [7:0] MODE_0B = 8'h0b;
    localparam logic [7:0] MODE_HOLD = 8'h0c;
    localparam logic [7:0] MODE_0E = 8'h0e;
    localparam logic [7:0] MODE_0F = 8'h0f;
    localparam logic [7:0] MODE_10 = 8'h10;
    localparam logic [7:0] MODE_11 = 8'h11;
    localparam logic [7:0] MODE_13 = 8'h13;
    localparam logic [7:0] MODE_14 = 8'h14;
    localparam logic [7:0] MODE_15 = 8'h15;
    localparam logic [7:0] MODE_16 = 8'h16;
    localparam logic [7:0] MODE_17 = 8'h17;
    localparam logic [7:0] MODE_1C = 8'h1c;
    localparam logic [7:0] MODE_1D = 8'h1d;
    localparam logic [7:0] ROLE_SHOULDER = 8'd2;
    localparam logic [7:0] LAYOUT_0 = 8'd0;
    localparam logic [7:0] LAYOUT_1 = 8'd1;

    logic [7:0]  m;
    logic [7:0]  d;
    logic [15:0] s;
    logic [7:0]  ah;
    logic [7:0]  f;
    logic [7:0]  sc;
    logic [7:0]  th;
    logic        ap;
    logic        sup;
    logic        alt;
    logic        adapter_proto;
    logic        owns;
    logic        hold_active;
    logic        pressed;
    logic [31:0] hold_diff;
    logic [3:0]  hat_idx;
    logic [12:0] b;

    assign m   = cfg.wheel_protocol;
    assign d   = item.dpad_bits;
    assign s   = item.wheel_button_bits;
    assign ah  = item.aux_history_bits;
    assign f   = item.adapter_button_bytes[7:0];
    assign sc  = item.adapter_button_bytes[15:8];
    assign th  = item.adapter_button_bytes[23:16];
    assign ap  = item.adapter_present;
    assign sup = s[13];
    assign alt = (m == MODE_0F) || (m == MODE_17);
    assign adapter_proto = (m == MODE_04) || (m == MODE_06) || (m == MODE_HOLD)
                        || (m == MODE_15);
    assign owns = ((m == MODE_04) || (m == MODE_06) || (m == MODE_15)) && ap;
    assign hold_active = (m == MODE_HOLD) && !ap;
    assign pressed     = s[7];
    assign hold_diff   = item.time_ms - hold.deadline;
    assign hat_idx     = {d[0], d[3], d[1], d[2]};

    always_comb
    begin
        b = '0;

        // wheel buttons
        if (m == MODE_0E)
        begin
            b[0]  = s[1];
            b[1]  = d[5];
            b[2]  = d[7];
            b[3]  = s[5];
            b[4]  = s[3];
            b[5]  = s[0];
            b[6]  = s[4];
            b[7]  = d[6];
            b[8]  = s[6];
            b[9]  = s[7];
            b[10] = ah[5];
            b[11] = ah[6];
        end
        else
        begin
            b[0] = d[5];
            b[1] = d[4] | (alt ? s[6] : s[10]);
            if ((m == MODE_0A) || (m == MODE_10))
            begin
                b[1] = b[1] | s[9];
            end
            if (cfg.adapter_layout != LAYOUT_0)
            begin
                b[2]  = d[6];
                b[11] = s[2];
            end
            b[3]  = d[7];
            b[4]  = s[3];
            b[5]  = s[0];
            b[10] = s[5];
            b[8]  = alt ? s[10] : s[6];
            b[9]  = alt ? s[8]  : s[7];
            if ((m == MODE_09) || (m == MODE_0B) || (m == MODE_1D))
            begin
                b[6] = 1'b0;
                b[7] = 1'b0;
            end
            else if (m == MODE_11)
            begin
                b[6]  = s[4];
                b[7]  = s[2];
                b[11] = s[1];
            end
            else
            begin
                b[6] = s[4];
                b[7] = s[1];
            end
        end

        // adapter buttons
        if (adapter_proto && ap)
        begin
            if (cfg.adapter_layout == LAYOUT_0)
            begin
                b[0]  = b[0] | sc[4];
                b[1]  = b[1] | th[2] | sc[3] | th[3];
                b[2]  = sc[2];
                b[3]  = b[3] | sc[1];
                b[6]  = b[6] | f[4];
                b[7]  = b[7] | f[6];
                b[8]  = b[8] | sc[0];
                b[9]  = b[9] | sc[5];
                b[10] = b[10] | f[5];
            end
            else if (cfg.adapter_layout == LAYOUT_1)
            begin
                b[0]  = f[6];
                b[1]  = th[2] | sc[1] | th[3];
                b[2]  = b[2] | sc[2];
                b[3]  = b[3] | f[4];
                b[6]  = b[6] | f[5];
                b[7]  = b[7] | sc[3];
                b[8]  = b[8] | f[7];
                b[9]  = b[9] | sc[0];
                b[10] = b[10] | th[1];
                b[11] = b[11] | sc[6];
            end
        end

        // auxiliary shoulders and system button
        if ((cfg.first_axis_role == ROLE_SHOULDER) || (cfg.second_axis_role == ROLE_SHOULDER))
        begin
            b[4] = b[4] | item.aux_button_pair[1];
            b[5] = b[5] | item.aux_button_pair[0];
        end
        b[12] = s[9];
        hold_next = hold;
        if ((m == MODE_0A) || (m == MODE_10) || (m == MODE_0E))
        begin
            b[12] = s[8];
        end
        else if (alt)
        begin
            b[12] = s[7];
        end
        else if ((m >= MODE_01) && (m <= MODE_03))
        begin
            b[12] = s[11];
            b[1]  = b[1] | s[9];
        end
        else if ((m == MODE_13) || (m == MODE_14) || (m == MODE_16) || (m == MODE_1C))
        begin
            b[12] = s[8];
            b[1]  = b[1] | s[9] | ((m == MODE_1C) & item.extra_button_bits[1]);
        end
        else if (adapter_proto && ap)
        begin
            if (cfg.adapter_layout == LAYOUT_1)
            begin
                b[12] = item.adapter_button_bytes[12];
            end
            else if (cfg.adapter_layout == LAYOUT_0)
            begin
                b[12] = item.adapter_button_bytes[7];
            end
        end
        else if (hold_active)
        begin
            if (!hold.pending && pressed)
            begin
                hold_next.deadline = item.time_ms + {16'd0, cfg.hold_time_ms};
                hold_next.pending  = 1'b1;
            end
            else if (hold.pending && !pressed)
            begin
                hold_next.pending = 1'b0;
            end
            else if (hold.pending && !hold_diff[31])
            begin
                // wrap-safe: deadline reached when the signed difference is >= 0
                b[12] = 1'b1;
            end
        end

        if ((m != MODE_0F) && (m != MODE_17) && (m != MODE_1C) && (m != MODE_HOLD) && !owns)
        begin
            b[1] = b[1] | s[10];
        end

        if (item.block_system_key || sup)
        begin
            b[12] = 1'b0;
        end

        report.report_buttons = b;
        report.hat_code = (item.block_hat || sup) ? HAT_NEUTRAL : hat_lookup(hat_idx);
    end

endmodule

// ===== rtl/core/wheel_button_report_mapper.sv =====
// ----------------------------------------------------------------------------
// wheel_button_report_mapper
// Maps one wheel button snapshot to one console report (hat and buttons).
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) carries one button snapshot per
//   transfer; report channel (report_valid/report_ready/report) returns one
//   report per snapshot, in order. The APB port sets the protocol mode,
//   adapter layout, axis roles and system button hold time; write it only
//   while no snapshot is in flight.
//   Path: each snapshot goes into the input register, then through the mapping
//   logic into the report register, which drives report_valid and report.
//   Throughput: one snapshot per cycle while report_ready is high; the mapping
//   and the 32-bit hold deadline add and compare fit between the two registers.
//   When report_ready is low the report register holds, the input register
//   still takes one more snapshot, then item_ready drops until the report
//   is taken.
//   Reset clears both valid flags, the hold tracker, and loads the register
//   defaults (hold time 3000 ms, all others 0).
// ----------------------------------------------------------------------------
`include "wheel_button_report_mapper_assert.svh"

module wheel_button_report_mapper
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  wbrm_pkg::in_item_t  item,
    output logic                report_valid,
    input  logic                report_ready,
    output wbrm_pkg::out_item_t report,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import wbrm_pkg::*;

    localparam logic [2:0] REG_PROTOCOL = 3'd0;
    localparam logic [2:0] REG_LAYOUT   = 3'd1;
    localparam logic [2:0] REG_ROLE1    = 3'd2;
    localparam logic [2:0] REG_ROLE2    = 3'd3;
    localparam logic [2:0] REG_HOLD     = 3'd4;

    in_item_t  item_reg;
    logic      item_valid_reg;
    out_item_t report_reg;
    logic      report_valid_reg;
    cfg_t      cfg_reg;
    hold_t     hold_reg;
    hold_t     hold_next;
    out_item_t report_next;
    logic      advance;
    logic      fire;
    logic      cfg_wr;
    logic [2:0] reg_idx;

    assign advance    = !report_valid_reg || report_ready;
    assign fire       = item_valid_reg && advance;
    assign item_ready = !item_valid_reg || advance;
    assign cfg_wr     = psel && penable && pwrite;
    assign reg_idx    = paddr[4:2];
    assign pready     = 1'b1;

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

    wbrm_map u_map
    (
        .item      (item_reg),
        .cfg       (cfg_reg),
        .hold      (hold_reg),
        .report    (report_next),
        .hold_next (hold_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            report_valid_reg <= 1'b0;
            hold_reg         <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                report_valid_reg <= item_valid_reg;
            end
            if (fire)
            begin
                hold_reg <= hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (fire)
        begin
            report_reg <= report_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wheel_protocol   <= '0;
            cfg_reg.adapter_layout   <= '0;
            cfg_reg.first_axis_role  <= '0;
            cfg_reg.second_axis_role <= '0;
            cfg_reg.hold_time_ms     <= HOLD_TIME_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_PROTOCOL: cfg_reg.wheel_protocol   <= pwdata[7:0];
                REG_LAYOUT:   cfg_reg.adapter_layout   <= pwdata[7:0];
                REG_ROLE1:    cfg_reg.first_axis_role  <= pwdata[7:0];
                REG_ROLE2:    cfg_reg.second_axis_role <= pwdata[7:0];
                REG_HOLD:     cfg_reg.hold_time_ms     <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PROTOCOL: prdata = {24'd0, cfg_reg.wheel_protocol};
            REG_LAYOUT:   prdata = {24'd0, cfg_reg.adapter_layout};
            REG_ROLE1:    prdata = {24'd0, cfg_reg.first_axis_role};
            REG_ROLE2:    prdata = {24'd0, cfg_reg.second_axis_role};
            REG_HOLD:     prdata = {16'd0, cfg_reg.hold_time_ms};
            default:      prdata = '0;
        endcase
    end

    // hold tracker only moves when a snapshot is mapped
    `WBRM_ASSERT_NEXT(a_hold_quiet, clk, rst_n, !fire, $stable(hold_reg))
    // every mapped snapshot lands in the report register
    `WBRM_ASSERT_NEXT(a_fire_report, clk, rst_n, fire, report_valid)
    `WBRM_ASSERT_NEXT(a_sys_blocked, clk, rst_n,
        fire && (item_reg.block_system_key || item_reg.wheel_button_bits[13]),
        !report.report_buttons[12])
    `WBRM_ASSERT_NEXT(a_hat_blocked, clk, rst_n,
        fire && (item_reg.block_hat || item_reg.wheel_button_bits[13]),
        report.hat_code == HAT_NEUTRAL)

endmodule
